// ----- src/rp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants of the random projection quantiser.
// Used by every file under src; depends on nothing else.

package rp_pkg;

  // Default matrix dimensions (rows are outputs, columns are samples).
  localparam int MAX_INPUT_DIM_DEF  = 64;
  localparam int MAX_TARGET_DIM_DEF = 64;

  // Field widths of the two channels.
  localparam int KIND_W   = 1;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 6;
  localparam int WEIGHT_W = 16;
  localparam int SAMPLE_W = 16;
  localparam int VALUE_W  = 8;
  localparam int INDEX_W  = 6;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_WEIGHT = 1'b0;
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 1'b1;

  // Configuration register widths and reset values.
  localparam int CFG_LEN_W    = 7;
  localparam int CFG_CNT_W    = 7;
  localparam int CFG_SCALE_W  = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 2;
  localparam logic [CFG_LEN_W-1:0]   INPUT_LENGTH_RST = 7'd64;
  localparam logic [CFG_CNT_W-1:0]   OUTPUT_COUNT_RST = 7'd16;
  localparam logic [CFG_SCALE_W-1:0] SCALE_RECIP_RST  = 16'd8192;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_INPUT_LENGTH = 2'd0,
    CFG_OUTPUT_COUNT = 2'd1,
    CFG_SCALE_RECIP  = 2'd2
  } rp_cfg_idx_t;

  // Arithmetic widths.
  localparam int PROD_W    = WEIGHT_W + SAMPLE_W;       // weight times sample
  localparam int ACC_W     = 40;                        // row accumulator
  localparam int SPLIT_W   = 16;                        // low part of the accumulator
  localparam int HI_W      = ACC_W - SPLIT_W;           // high part, signed
  localparam int PHI_W     = HI_W + CFG_SCALE_W + 1;    // high partial product
  localparam int PLO_W     = SPLIT_W + CFG_SCALE_W;     // low partial product
  localparam int SCALED_W  = ACC_W + CFG_SCALE_W + 1;   // full scaled value
  localparam int Q_SHIFT   = 36;
  localparam int Q_MAX     = 127;
  localparam int Q_MIN     = -128;

  // Added to negative values before the shift so that it truncates toward zero.
  localparam logic signed [SCALED_W-1:0] TRUNC_BIAS =
    (SCALED_W'(1) <<< Q_SHIFT) - SCALED_W'(1);

  // Control of the accumulator ring.
  typedef struct packed {
    logic shift;
    logic clear;
  } rp_ring_ctl_t;

endpackage

// ----- src/rp_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the random projection quantiser.
// Depends on rp_pkg for the field widths.

interface rp_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [rp_pkg::KIND_W-1:0]      kind;
  logic        [rp_pkg::ROW_W-1:0]       row;
  logic        [rp_pkg::COL_W-1:0]       col;
  logic signed [rp_pkg::WEIGHT_W-1:0]    weight;
  logic signed [rp_pkg::SAMPLE_W-1:0]    sample;

  modport source(output valid, kind, row, col, weight, sample, input ready);
  modport sink(input valid, kind, row, col, weight, sample, output ready);
endinterface

interface rp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rp_pkg::VALUE_W-1:0]     value;
  logic        [rp_pkg::INDEX_W-1:0]     index;
  logic                                  last;

  modport source(output valid, value, index, last, input ready);
  modport sink(input valid, value, index, last, output ready);
endinterface

// ----- src/rp_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Uses rp_pkg only for its default parameters; holds the projection weights.

module rp_ram #(
  parameter int WIDTH = rp_pkg::WEIGHT_W,
  parameter int DEPTH = rp_pkg::MAX_INPUT_DIM_DEF * rp_pkg::MAX_TARGET_DIM_DEF
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/rp_cell.sv -----
`timescale 1ns / 1ps
// One accumulator cell of the row ring: holds one 40-bit row sum.
// Depends on rp_pkg for the accumulator width and the ring control type.

module rp_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rp_pkg::rp_ring_ctl_t              ctl,
  input  logic signed [rp_pkg::ACC_W-1:0]   d_in,
  output logic signed [rp_pkg::ACC_W-1:0]   q
);

  logic signed [rp_pkg::ACC_W-1:0] acc_r;

  // The sum is cleared at the end of a vector, otherwise it takes the
  // neighbour's value whenever the ring moves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.clear) begin
      acc_r <= '0;
    end else if (ctl.shift) begin
      acc_r <= d_in;
    end
  end

  assign q = acc_r;

endmodule

// ----- src/rp_scaler.sv -----
`timescale 1ns / 1ps
// Scaling and int8 quantisation pipeline with the result register.
// Depends on rp_pkg and the rp_out_if interface.

module rp_scaler (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_vld,
  input  logic signed [rp_pkg::ACC_W-1:0]        in_acc,
  input  logic        [rp_pkg::INDEX_W-1:0]      in_index,
  input  logic                                   in_last,
  input  logic        [rp_pkg::CFG_SCALE_W-1:0]  scale,
  output logic                                   take,
  rp_out_if.source                               out_ch
);

  localparam int SW = rp_pkg::SCALED_W;

  logic                                  adv;

  // Stage one: partial products.
  logic                                  s1_vld_r;
  logic signed [rp_pkg::PHI_W-1:0]       p_hi_r;
  logic        [rp_pkg::PLO_W-1:0]       p_lo_r;
  logic        [rp_pkg::INDEX_W-1:0]     s1_index_r;
  logic                                  s1_last_r;
  logic signed [rp_pkg::PHI_W-1:0]       p_hi_nxt;
  logic        [rp_pkg::PLO_W-1:0]       p_lo_nxt;

  // Stage two: full scaled value.
  logic                                  s2_vld_r;
  logic signed [SW-1:0]                  scaled_r;
  logic        [rp_pkg::INDEX_W-1:0]     s2_index_r;
  logic                                  s2_last_r;
  logic signed [SW-1:0]                  scaled_nxt;

  // Result register.
  logic                                  out_vld_r;
  logic signed [rp_pkg::VALUE_W-1:0]     value_r;
  logic        [rp_pkg::INDEX_W-1:0]     index_r;
  logic                                  last_r;
  logic signed [SW-1:0]                  biased;
  logic signed [SW-1:0]                  q_full;
  logic signed [rp_pkg::VALUE_W-1:0]     value_nxt;

  // The whole pipeline moves when the result register is free or being taken.
  assign adv  = !out_vld_r || out_ch.ready;
  assign take = adv;

  // The accumulator is split so that neither multiplier exceeds 24 by 17 bits.
  assign p_hi_nxt = $signed(in_acc[rp_pkg::ACC_W-1:rp_pkg::SPLIT_W]) * $signed({1'b0, scale});
  assign p_lo_nxt = in_acc[rp_pkg::SPLIT_W-1:0] * scale;

  // Recombine the partial products.
  assign scaled_nxt = (SW'(p_hi_r) <<< rp_pkg::SPLIT_W) + $signed(SW'(p_lo_r));

  // Shift right with truncation toward zero, then saturate to int8.
  always_comb begin
    biased = scaled_r + (scaled_r[SW-1] ? rp_pkg::TRUNC_BIAS : '0);
    q_full = biased >>> rp_pkg::Q_SHIFT;
    if (q_full > $signed(SW'(rp_pkg::Q_MAX))) begin
      value_nxt = rp_pkg::VALUE_W'(rp_pkg::Q_MAX);
    end else if (q_full < $signed(SW'(rp_pkg::Q_MIN))) begin
      value_nxt = rp_pkg::VALUE_W'(rp_pkg::Q_MIN);
    end else begin
      value_nxt = q_full[rp_pkg::VALUE_W-1:0];
    end
  end

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_vld;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
    end
  end

  // Payload of the stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      p_hi_r     <= p_hi_nxt;
      p_lo_r     <= p_lo_nxt;
      s1_index_r <= in_index;
      s1_last_r  <= in_last;
      scaled_r   <= scaled_nxt;
      s2_index_r <= s1_index_r;
      s2_last_r  <= s1_last_r;
      value_r    <= value_nxt;
      index_r    <= s2_index_r;
      last_r     <= s2_last_r;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.value = value_r;
  assign out_ch.index = index_r;
  assign out_ch.last  = last_r;

endmodule

// ----- src/random_projection_int8_quantizer.sv -----
`timescale 1ns / 1ps
// Random projection quantiser: a weight load is taken while idle; for a sample, the
// row sums rotate once through one shared multiply-accumulate fed by the weight
// RAM's single read port; no new item is taken during the pass.
// The last sample of a vector is followed by one result per cycle (the effective
// output count of them), each through the scaler pipeline, held while out is stalled.
// Reset clears the row sums, the sample count and the registers; weights are not cleared.

module random_projection_int8_quantizer #(
  parameter int MAX_INPUT_DIM  = rp_pkg::MAX_INPUT_DIM_DEF,
  parameter int MAX_TARGET_DIM = rp_pkg::MAX_TARGET_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  rp_in_if.sink                              in_ch,
  rp_out_if.source                           out_ch,
  input  logic                               cfg_we,
  input  logic [rp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int DEPTH  = MAX_TARGET_DIM * MAX_INPUT_DIM;
  localparam int AW     = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int RW     = MAX_TARGET_DIM > 1 ? $clog2(MAX_TARGET_DIM) : 1;
  localparam int CW     = MAX_INPUT_DIM > 1 ? $clog2(MAX_INPUT_DIM) : 1;
  localparam int LEN_W  = $clog2(MAX_INPUT_DIM + 1) > rp_pkg::CFG_LEN_W ?
                          $clog2(MAX_INPUT_DIM + 1) : rp_pkg::CFG_LEN_W;
  localparam int ACC_W  = rp_pkg::ACC_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_EMIT
  } state_t;

  // Configuration registers.
  logic [rp_pkg::CFG_LEN_W-1:0]    input_length_r;
  logic [rp_pkg::CFG_CNT_W-1:0]    output_count_r;
  logic [rp_pkg::CFG_SCALE_W-1:0]  scale_recip_r;

  // Sequencer state.
  state_t                          state_r, state_nxt;
  logic [LEN_W-1:0]                count_r, count_nxt;
  logic [RW-1:0]                   rd_row_r, rd_row_nxt;
  logic [RW-1:0]                   emit_row_r, emit_row_nxt;
  logic                            issue_r, issue_nxt;
  logic                            rd_vld_r, rd_vld_nxt;
  logic                            rd_last_r, rd_last_nxt;
  logic                            prod_vld_r, prod_vld_nxt;
  logic                            prod_last_r, prod_last_nxt;
  logic signed [rp_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [CW-1:0]                   col_r, col_nxt;
  logic signed [rp_pkg::PROD_W-1:0] prod_r, prod_nxt;

  // Weight memory.
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [AW-1:0]                   ram_raddr;
  logic [rp_pkg::WEIGHT_W-1:0]     ram_rdata;
  logic                            wr_in_range;

  // Ring and scaler.
  rp_pkg::rp_ring_ctl_t            ring_ctl;
  logic signed [ACC_W-1:0]         acc_q [MAX_TARGET_DIM];
  logic signed [ACC_W-1:0]         tail_in;
  logic                            sc_vld;
  logic                            sc_take;

  // Effective lengths.
  logic [LEN_W-1:0]                len_ext, eff_len;
  logic [LEN_W-1:0]                cnt_ext, cnt_a, eff_cnt, last_row;
  logic [LEN_W-1:0]                count_inc;
  logic                            emit_last;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_length_r <= rp_pkg::INPUT_LENGTH_RST;
      output_count_r <= rp_pkg::OUTPUT_COUNT_RST;
      scale_recip_r  <= rp_pkg::SCALE_RECIP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rp_pkg::CFG_INPUT_LENGTH: begin
          input_length_r <= cfg_data[rp_pkg::CFG_LEN_W-1:0];
        end
        rp_pkg::CFG_OUTPUT_COUNT: begin
          output_count_r <= cfg_data[rp_pkg::CFG_CNT_W-1:0];
        end
        rp_pkg::CFG_SCALE_RECIP: begin
          scale_recip_r <= cfg_data[rp_pkg::CFG_SCALE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Vector length and number of results after the limits are applied.
  always_comb begin
    len_ext = LEN_W'(input_length_r);
    if (input_length_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_ext > LEN_W'(MAX_INPUT_DIM)) begin
      eff_len = LEN_W'(MAX_INPUT_DIM);
    end else begin
      eff_len = len_ext;
    end
    cnt_ext  = (output_count_r == '0) ? LEN_W'(1) : LEN_W'(output_count_r);
    cnt_a    = (cnt_ext > eff_len) ? eff_len : cnt_ext;
    eff_cnt  = (cnt_a > LEN_W'(MAX_TARGET_DIM)) ? LEN_W'(MAX_TARGET_DIM) : cnt_a;
    last_row = eff_cnt - LEN_W'(1);
  end

  assign count_inc = count_r + LEN_W'(1);
  assign emit_last = (LEN_W'(emit_row_r) == last_row);

  // Weight load addressing.
  assign wr_in_range = (32'(in_ch.row) < 32'(MAX_TARGET_DIM)) &&
                       (32'(in_ch.col) < 32'(MAX_INPUT_DIM));
  assign ram_waddr   = AW'(32'(in_ch.row) * MAX_INPUT_DIM + 32'(in_ch.col));
  assign ram_raddr   = AW'(32'(rd_row_r) * MAX_INPUT_DIM + 32'(col_r));

  assign in_ch.ready = (state_r == ST_IDLE);

  // Sequencer next state.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_row_nxt    = rd_row_r;
    emit_row_nxt  = emit_row_r;
    issue_nxt     = issue_r;
    sample_nxt    = sample_r;
    col_nxt       = col_r;
    ram_we        = 1'b0;
    sc_vld        = 1'b0;
    ring_ctl.shift = prod_vld_r;
    ring_ctl.clear = 1'b0;

    // Read, multiply and add pipeline of the sample pass.
    rd_vld_nxt    = issue_r;
    rd_last_nxt   = issue_r && (rd_row_r == RW'(MAX_TARGET_DIM - 1));
    prod_vld_nxt  = rd_vld_r;
    prod_last_nxt = rd_last_r;
    prod_nxt      = $signed(ram_rdata) * sample_r;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.kind == rp_pkg::KIND_SAMPLE) begin
            sample_nxt = in_ch.sample;
            col_nxt    = count_r[CW-1:0];
            rd_row_nxt = '0;
            issue_nxt  = 1'b1;
            state_nxt  = ST_MAC;
          end else begin
            ram_we = wr_in_range;
          end
        end
      end
      ST_MAC: begin
        // Issue one weight read per row.
        if (issue_r) begin
          if (rd_row_r == RW'(MAX_TARGET_DIM - 1)) begin
            issue_nxt = 1'b0;
          end else begin
            rd_row_nxt = rd_row_r + RW'(1);
          end
        end
        // The last row's product has entered the ring.
        if (prod_vld_r && prod_last_r) begin
          if (count_inc >= eff_len) begin
            count_nxt    = '0;
            emit_row_nxt = '0;
            state_nxt    = ST_EMIT;
          end else begin
            count_nxt = count_inc;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        // Hand the head row to the scaler whenever it can take one.
        if (sc_take) begin
          sc_vld         = 1'b1;
          ring_ctl.shift = 1'b1;
          if (emit_last) begin
            ring_ctl.clear = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            emit_row_nxt = emit_row_r + RW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_row_r    <= '0;
      emit_row_r  <= '0;
      issue_r     <= 1'b0;
      rd_vld_r    <= 1'b0;
      rd_last_r   <= 1'b0;
      prod_vld_r  <= 1'b0;
      prod_last_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_row_r    <= rd_row_nxt;
      emit_row_r  <= emit_row_nxt;
      issue_r     <= issue_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_last_r   <= rd_last_nxt;
      prod_vld_r  <= prod_vld_nxt;
      prod_last_r <= prod_last_nxt;
    end
    sample_r <= sample_nxt;
    col_r    <= col_nxt;
    prod_r   <= prod_nxt;
  end

  rp_ram #(
    .WIDTH (rp_pkg::WEIGHT_W),
    .DEPTH (DEPTH)
  ) u_weight_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.weight),
    .re    (issue_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The head row picks up its product on its way to the tail.
  assign tail_in = acc_q[0] + (prod_vld_r ? ACC_W'(prod_r) : '0);

  // Ring of row accumulators; row 0 sits at the head.
  for (genvar k = 0; k < MAX_TARGET_DIM; k++) begin : g_ring
    if (k == MAX_TARGET_DIM - 1) begin : g_tail
      rp_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ring_ctl),
        .d_in  (tail_in),
        .q     (acc_q[k])
      );
    end else begin : g_body
      rp_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ring_ctl),
        .d_in  (acc_q[k+1]),
        .q     (acc_q[k])
      );
    end
  end

  rp_scaler u_scaler (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sc_vld),
    .in_acc   (acc_q[0]),
    .in_index (rp_pkg::INDEX_W'(emit_row_r)),
    .in_last  (emit_last),
    .scale    (scale_recip_r),
    .take     (sc_take),
    .out_ch   (out_ch)
  );

endmodule

// ----- sim/random_projection_int8_quantizer_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the random projection int8 quantiser: loads the weight
// columns in use, projects vectors under several register settings and checks each result.
// Depends on rp_pkg, the channel interfaces in rp_if.sv and the quantiser itself.

module random_projection_int8_quantizer_test;

  localparam int ROWS          = rp_pkg::MAX_TARGET_DIM_DEF;
  localparam int COLS          = rp_pkg::MAX_INPUT_DIM_DEF;
  localparam int USED_COLS     = 4;
  localparam int SETTLE_CYCLES = ROWS + 16;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 110;
  localparam int LONG_HOLD     = 600;

  // One transfer on the input channel.
  typedef struct {
    logic [rp_pkg::KIND_W-1:0]          kind;
    logic [rp_pkg::ROW_W-1:0]           row;
    logic [rp_pkg::COL_W-1:0]           col;
    logic signed [rp_pkg::WEIGHT_W-1:0] weight;
    logic signed [rp_pkg::SAMPLE_W-1:0] sample;
  } feed_t;

  // One projected result.
  typedef struct {
    logic signed [rp_pkg::VALUE_W-1:0] value;
    logic [rp_pkg::INDEX_W-1:0]        index;
    logic                              last;
  } projection_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           cfg_we    = 1'b0;
  logic [rp_pkg::CFG_INDEX_W-1:0] cfg_index = rp_pkg::CFG_INPUT_LENGTH;
  logic [rp_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  rp_in_if  in_ch ();
  rp_out_if out_ch ();

  random_projection_int8_quantizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow state of the projection, kept in step with every accepted transfer.
  logic signed [rp_pkg::WEIGHT_W-1:0] weight_copy [ROWS][COLS];
  logic [rp_pkg::ACC_W-1:0]           row_sums [ROWS];
  int                                 samples_seen = 0;
  logic [rp_pkg::CFG_LEN_W-1:0]       length_reg = rp_pkg::INPUT_LENGTH_RST;
  logic [rp_pkg::CFG_CNT_W-1:0]       count_reg  = rp_pkg::OUTPUT_COUNT_RST;
  logic [rp_pkg::CFG_SCALE_W-1:0]     scale_reg  = rp_pkg::SCALE_RECIP_RST;

  projection_t pending_projections[$];
  int          mismatch_count    = 0;
  int          items_sent        = 0;
  bit          idling_on         = 1'b1;
  int          hold_off_request  = 0;

  // Effective vector length after the zero and upper clamps.
  function automatic int active_length();
    int n;
    n = length_reg;
    if (n == 0) n = 1;
    if (n > COLS) n = COLS;
    return n;
  endfunction

  // Effective number of results per vector.
  function automatic int active_count();
    int n;
    n = count_reg;
    if (n == 0) n = 1;
    if (n > active_length()) n = active_length();
    if (n > ROWS) n = ROWS;
    return n;
  endfunction

  // Applies one accepted transfer to the shadow state and queues any results it causes.
  function automatic void predict_projection(input feed_t f);
    logic signed [rp_pkg::PROD_W-1:0] prod;
    logic signed [rp_pkg::ACC_W-1:0]  sum;
    longint                           scaled;
    longint                           quot;
    int                               last_row;
    projection_t                      r;
    if (f.kind == rp_pkg::KIND_WEIGHT) begin
      weight_copy[f.row][f.col] = f.weight;
      return;
    end
    if (samples_seen < COLS) begin
      for (int i = 0; i < ROWS; i++) begin
        prod = weight_copy[i][samples_seen] * f.sample;
        row_sums[i] = row_sums[i] +
                      {{(rp_pkg::ACC_W - rp_pkg::PROD_W){prod[rp_pkg::PROD_W-1]}}, prod};
      end
    end
    samples_seen++;
    if (samples_seen < active_length()) return;
    last_row = active_count() - 1;
    for (int i = 0; i <= last_row; i++) begin
      sum    = row_sums[i];
      scaled = sum * longint'(scale_reg);
      // Signed division truncates toward zero, as the block's shift does.
      quot   = scaled / (longint'(1) <<< rp_pkg::Q_SHIFT);
      if (quot > rp_pkg::Q_MAX) quot = rp_pkg::Q_MAX;
      if (quot < rp_pkg::Q_MIN) quot = rp_pkg::Q_MIN;
      r.value = quot[rp_pkg::VALUE_W-1:0];
      r.index = i[rp_pkg::INDEX_W-1:0];
      r.last  = (i == last_row);
      pending_projections.push_back(r);
    end
    foreach (row_sums[i]) row_sums[i] = '0;
    samples_seen = 0;
  endfunction

  // Offers one item and waits for its transfer; valid stays high afterwards.
  task automatic send_item(input feed_t f);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.kind   <= f.kind;
    in_ch.row    <= f.row;
    in_ch.col    <= f.col;
    in_ch.weight <= f.weight;
    in_ch.sample <= f.sample;
    do @(posedge clk); while (!in_ch.ready);
    predict_projection(f);
    items_sent++;
  endtask

  task automatic send_weight(input int r, input int c,
                             input logic signed [rp_pkg::WEIGHT_W-1:0] w);
    feed_t f;
    f.kind   = rp_pkg::KIND_WEIGHT;
    f.row    = r[rp_pkg::ROW_W-1:0];
    f.col    = c[rp_pkg::COL_W-1:0];
    f.weight = w;
    f.sample = rp_pkg::SAMPLE_W'($urandom);
    send_item(f);
  endtask

  task automatic send_sample(input logic signed [rp_pkg::SAMPLE_W-1:0] s);
    feed_t f;
    f.kind   = rp_pkg::KIND_SAMPLE;
    f.row    = rp_pkg::ROW_W'($urandom);
    f.col    = rp_pkg::COL_W'($urandom);
    f.weight = rp_pkg::WEIGHT_W'($urandom);
    f.sample = s;
    send_item(f);
  endtask

  // Full range, medium or tiny samples, so that results both saturate and not.
  function automatic logic signed [rp_pkg::SAMPLE_W-1:0] random_sample(input int magnitude);
    case (magnitude)
      0:       return rp_pkg::SAMPLE_W'($urandom);
      1:       return rp_pkg::SAMPLE_W'($urandom_range(0, 8190)) - rp_pkg::SAMPLE_W'(4095);
      default: return rp_pkg::SAMPLE_W'($urandom_range(0, 510)) - rp_pkg::SAMPLE_W'(255);
    endcase
  endfunction

  // Stops offering, waits for every queued result, then lets the block finish its pass.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (pending_projections.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input rp_pkg::rp_cfg_idx_t idx,
                                input logic [rp_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      rp_pkg::CFG_INPUT_LENGTH: length_reg = data[rp_pkg::CFG_LEN_W-1:0];
      rp_pkg::CFG_OUTPUT_COUNT: count_reg  = data[rp_pkg::CFG_CNT_W-1:0];
      rp_pkg::CFG_SCALE_RECIP:  scale_reg  = data[rp_pkg::CFG_SCALE_W-1:0];
      default: ;
    endcase
  endtask

  // Writes all three registers once the block is idle; unused upper bits of length and count carry noise.
  task automatic configure(input logic [rp_pkg::CFG_LEN_W-1:0] len,
                           input logic [rp_pkg::CFG_CNT_W-1:0] cnt,
                           input logic [rp_pkg::CFG_SCALE_W-1:0] scale);
    logic [rp_pkg::CFG_DATA_W-1:0] data;
    settle_block();
    data = rp_pkg::CFG_DATA_W'($urandom);
    data[rp_pkg::CFG_LEN_W-1:0] = len;
    write_register(rp_pkg::CFG_INPUT_LENGTH, data);
    data = rp_pkg::CFG_DATA_W'($urandom);
    data[rp_pkg::CFG_CNT_W-1:0] = cnt;
    write_register(rp_pkg::CFG_OUTPUT_COUNT, data);
    write_register(rp_pkg::CFG_SCALE_RECIP, scale);
    cfg_we <= 1'b0;
  endtask

  // Every weight of the columns in use is written before any sample, since a sample
  // reads its whole column; vectors are kept within those columns.
  task automatic test_weight_load();
    logic signed [rp_pkg::WEIGHT_W-1:0] w;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < USED_COLS; c++) begin
        case ($urandom_range(0, 15))
          0:       w = 16'sh7FFF;
          1:       w = 16'sh8000;
          2:       w = '0;
          default: w = rp_pkg::WEIGHT_W'($urandom);
        endcase
        send_weight(r, c, w);
      end
    end
  endtask

  // Part of a vector under the reset settings; the reset length is long, so no
  // result comes yet and the next setting finishes it.
  task automatic test_reset_defaults();
    repeat (USED_COLS - 1) send_sample(random_sample(1));
  endtask

  task automatic test_directed_vectors();
    // The first sample ends the vector left open; then sample extremes with the
    // largest scale.
    configure(7'd4, 7'd4, 16'hFFFF);
    send_sample(random_sample(1));
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sh0001);
    // Zero length and zero count both act as one; zero scale gives zero.
    configure(7'd0, 7'd0, 16'h0000);
    send_sample(16'shFFFF);
    // A count above the length is cut down to the length.
    configure(7'd3, 7'd100, 16'd4096);
    repeat (3) send_sample(random_sample(0));
  endtask

  // Lowering the length part-way through a vector ends it at the next sample.
  task automatic test_length_lowered();
    configure(7'd8, 7'd3, 16'd16384);
    repeat (3) send_sample(random_sample(1));
    configure(7'd2, 7'd3, 16'd16384);
    send_sample(random_sample(1));
  endtask

  // The receiver holds off while vectors keep arriving, so the input stalls.
  task automatic test_backpressure();
    configure(7'd4, 7'd4, 16'd2048);
    hold_off_request = LONG_HOLD;
    repeat (24) send_sample(random_sample(1));
    settle_block();
  endtask

  // Phases of random settings; vectors are mostly complete, with stray weight
  // writes and the odd partial vector left for the next setting to finish.
  task automatic test_random_phases();
    int                             start;
    int                             phase;
    int                             phase_end;
    int                             magnitude;
    logic [rp_pkg::CFG_LEN_W-1:0]   len;
    logic [rp_pkg::CFG_CNT_W-1:0]   cnt;
    logic [rp_pkg::CFG_SCALE_W-1:0] scale;
    start = items_sent;
    phase = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      idling_on = (items_sent - start) < RANDOM_ITEMS - 40;
      case (phase)
        0: begin
          len = 7'd1;  cnt = 7'd127; scale = 16'hFFFF;
        end
        1: begin
          len = rp_pkg::CFG_LEN_W'(USED_COLS); cnt = 7'd127; scale = 16'd3000;
        end
        2: begin
          len = rp_pkg::CFG_LEN_W'(USED_COLS); cnt = 7'd64;  scale = 16'h0000;
        end
        default: begin
          len = rp_pkg::CFG_LEN_W'($urandom_range(0, USED_COLS));
          cnt = rp_pkg::CFG_CNT_W'($urandom_range(0, 127));
          if ($urandom_range(0, 3) == 0)
            scale = rp_pkg::CFG_SCALE_W'($urandom_range(0, 1) * 16'hFFFF);
          else
            scale = rp_pkg::CFG_SCALE_W'($urandom);
        end
      endcase
      configure(len, cnt, scale);
      phase_end = items_sent + $urandom_range(15, 30);
      while (items_sent < phase_end) begin
        magnitude = $urandom_range(0, 2);
        do begin
          if ($urandom_range(0, 9) == 0)
            send_weight($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
                        rp_pkg::WEIGHT_W'($urandom));
          send_sample(random_sample(magnitude));
        end while (samples_seen != 0);
      end
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) send_sample(random_sample($urandom_range(0, 2)));
      phase++;
    end
  endtask

  // Result checking and receiver stalls.
  initial begin : result_monitor
    projection_t want;
    projection_t got;
    int          hold_left;
    int          stall_left;
    hold_left  = 0;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.value = out_ch.value;
        got.index = out_ch.index;
        got.last  = out_ch.last;
        if (pending_projections.size() == 0) begin
          $display("%0t: result with none expected: value %0d index %0d last %0b",
                   $time, got.value, got.index, got.last);
          mismatch_count++;
        end else begin
          want = pending_projections.pop_front();
          if (got.value !== want.value) begin
            $display("%0t: value expected %0d, actual %0d", $time, want.value, got.value);
            mismatch_count++;
          end
          if (got.index !== want.index) begin
            $display("%0t: index expected %0d, actual %0d", $time, want.index, got.index);
            mismatch_count++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %0b, actual %0b", $time, want.last, got.last);
            mismatch_count++;
          end
        end
      end
      // Choose the ready level for the next cycle.
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_off_request > 0) begin
        hold_left        = hold_off_request;
        hold_off_request = 0;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Ends a run that has stopped making progress.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : main_sequence
    in_ch.valid  <= 1'b0;
    in_ch.kind   <= rp_pkg::KIND_WEIGHT;
    in_ch.row    <= '0;
    in_ch.col    <= '0;
    in_ch.weight <= '0;
    in_ch.sample <= '0;
    foreach (row_sums[i]) row_sums[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_weight_load();
    test_reset_defaults();
    test_directed_vectors();
    test_length_lowered();
    test_backpressure();
    test_random_phases();
    settle_block();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
